// File: rtl/core/twspi_pkg.sv
`timescale 1ns / 1ps
// Package for the three-wire serial register/FIFO master.
// Holds operation codes, sequencer phase type, timing constants and the result record.
package twspi_pkg;

    // Transfer width; the shift width and bit-section unit counts below follow from it
    localparam int DATA_BITS = 8;

    // Operation codes carried by an input item
    localparam logic [2:0] OP_TICK    = 3'd0;  // also marks the idle sequencer
    localparam logic [2:0] OP_REG_WR  = 3'd1;
    localparam logic [2:0] OP_REG_RD  = 3'd2;
    localparam logic [2:0] OP_FIFO_WR = 3'd3;
    localparam logic [2:0] OP_FIFO_RD = 3'd4;

    // Unit counts of the waveform sections
    localparam int REG_LEAD_UNITS  = 2;
    localparam int FIFO_LEAD_UNITS = 3;
    localparam int REG_TAIL_UNITS  = 2;
    localparam int FIFO_TAIL_UNITS = 4;
    localparam int GAP_UNITS       = 6;
    localparam int UNIT_W          = 3;

    // Bit section: two units per bit; register access carries address then data
    localparam int SHIFT_W         = 2 * DATA_BITS;
    localparam int ADDR_UNITS      = 2 * DATA_BITS;
    localparam int FIFO_BIT_UNITS  = 2 * DATA_BITS;
    localparam int REG_BIT_UNITS   = 4 * DATA_BITS;
    localparam int BIT_W           = $clog2(REG_BIT_UNITS);

    typedef enum logic [4:0] {
        PH_IDLE = 5'b00001,
        PH_LEAD = 5'b00010,
        PH_BITS = 5'b00100,
        PH_TAIL = 5'b01000,
        PH_GAP  = 5'b10000
    } t_phase;

    // Pin levels and status for one item
    typedef struct packed {
        logic                 clock_out;
        logic                 line_out;
        logic                 line_drive;
        logic                 reg_select_n;
        logic                 fifo_select_n;
        logic                 busy_res;
        logic                 done_res;
        logic [DATA_BITS-1:0] read_byte;
        logic                 read_valid;
    } t_result;

endpackage

// File: rtl/core/twspi_seq.sv
`timescale 1ns / 1ps
// Transfer sequencer: state registers and single-pass next-state/pin logic per item.
// Depends on twspi_pkg.
module twspi_seq (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_take,
    input  logic [2:0]                     i_operation,
    input  logic [6:0]                     i_reg_address,
    input  logic [twspi_pkg::DATA_BITS-1:0] i_write_byte,
    input  logic                           i_line_in,
    output twspi_pkg::t_result             o_res
);
    import twspi_pkg::*;

    localparam logic [UNIT_W-1:0] REG_LEAD_LAST  = UNIT_W'(REG_LEAD_UNITS - 1);
    localparam logic [UNIT_W-1:0] FIFO_LEAD_LAST = UNIT_W'(FIFO_LEAD_UNITS - 1);
    localparam logic [UNIT_W-1:0] REG_TAIL_LAST  = UNIT_W'(REG_TAIL_UNITS - 1);
    localparam logic [UNIT_W-1:0] FIFO_TAIL_LAST = UNIT_W'(FIFO_TAIL_UNITS - 1);
    localparam logic [UNIT_W-1:0] GAP_LAST       = UNIT_W'(GAP_UNITS - 1);
    localparam logic [BIT_W-1:0]  REG_BITS_LAST  = BIT_W'(REG_BIT_UNITS - 1);
    localparam logic [BIT_W-1:0]  FIFO_BITS_LAST = BIT_W'(FIFO_BIT_UNITS - 1);
    localparam logic [BIT_W-1:0]  ADDR_END       = BIT_W'(ADDR_UNITS);

    t_phase                r_phase, n_phase, eff_phase;
    logic [2:0]            r_active_op, n_active_op, eff_op;
    logic [UNIT_W-1:0]     r_unit, n_unit, eff_unit;
    logic [BIT_W-1:0]      r_bit, n_bit, eff_bit;
    logic [SHIFT_W-1:0]    r_shift, n_shift, eff_shift;
    logic [DATA_BITS-1:0]  r_capture, n_capture, eff_capture;
    logic                  r_latch, n_latch, eff_latch;

    logic start, advance, is_reg, released, bitv, last;

    always_comb begin
        start = (r_phase == PH_IDLE) &&
                (i_operation == OP_REG_WR || i_operation == OP_REG_RD ||
                 i_operation == OP_FIFO_WR || i_operation == OP_FIFO_RD);

        // Effective state for this unit: a starting command is its own first unit
        eff_phase   = r_phase;
        eff_op      = r_active_op;
        eff_unit    = r_unit;
        eff_bit     = r_bit;
        eff_shift   = r_shift;
        eff_capture = r_capture;
        eff_latch   = r_latch;
        if (start) begin
            eff_phase   = PH_LEAD;
            eff_op      = i_operation;
            eff_unit    = '0;
            eff_bit     = '0;
            eff_capture = '1;
            case (i_operation)
                OP_REG_WR:  eff_shift = {1'b0, i_reg_address, i_write_byte};
                OP_REG_RD:  eff_shift = {1'b1, i_reg_address, {DATA_BITS{1'b0}}};
                OP_FIFO_WR: eff_shift = {i_write_byte, {DATA_BITS{1'b0}}};
                default:    eff_shift = '0;
            endcase
            if (i_operation == OP_REG_WR || i_operation == OP_REG_RD) begin
                eff_latch = 1'b1;
            end
        end

        advance  = start || (r_phase != PH_IDLE && i_operation == OP_TICK);
        is_reg   = (eff_op == OP_REG_WR) || (eff_op == OP_REG_RD);
        released = (eff_phase == PH_BITS) &&
                   ((eff_op == OP_FIFO_RD) || (eff_op == OP_REG_RD && eff_bit >= ADDR_END));
        bitv     = eff_shift[SHIFT_W-1];

        // Step the sequencer
        n_phase     = eff_phase;
        n_active_op = eff_op;
        n_unit      = eff_unit;
        n_bit       = eff_bit;
        n_shift     = eff_shift;
        n_capture   = eff_capture;
        n_latch     = eff_latch;
        last        = 1'b0;
        unique case (eff_phase)
            PH_IDLE: begin
            end
            PH_LEAD: begin
                if (eff_unit != (is_reg ? REG_LEAD_LAST : FIFO_LEAD_LAST)) begin
                    n_unit = eff_unit + 1'b1;
                end else begin
                    n_phase = PH_BITS;
                    n_bit   = '0;
                end
            end
            PH_BITS: begin
                if (released) begin
                    if (eff_bit[0]) begin
                        n_capture = {eff_capture[DATA_BITS-2:0], i_line_in};
                    end
                end else begin
                    n_latch = bitv;
                end
                if (eff_bit[0]) begin
                    n_shift = {eff_shift[SHIFT_W-2:0], 1'b0};
                end
                if (eff_bit != (is_reg ? REG_BITS_LAST : FIFO_BITS_LAST)) begin
                    n_bit = eff_bit + 1'b1;
                end else begin
                    n_phase = PH_TAIL;
                    n_unit  = '0;
                    n_bit   = '0;
                end
            end
            PH_TAIL: begin
                if (eff_unit != (is_reg ? REG_TAIL_LAST : FIFO_TAIL_LAST)) begin
                    n_unit = eff_unit + 1'b1;
                end else if (is_reg) begin
                    last = 1'b1;
                end else begin
                    n_phase = PH_GAP;
                    n_unit  = '0;
                end
            end
            PH_GAP: begin
                if (eff_unit != GAP_LAST) begin
                    n_unit = eff_unit + 1'b1;
                end else begin
                    last = 1'b1;
                end
            end
            default: begin
            end
        endcase
        if (last) begin
            if (is_reg) begin
                n_latch = 1'b1;
            end
            n_active_op = OP_TICK;
            n_phase     = PH_IDLE;
            n_unit      = '0;
            n_bit       = '0;
        end
        if (!advance) begin
            last        = 1'b0;
            n_phase     = r_phase;
            n_active_op = r_active_op;
            n_unit      = r_unit;
            n_bit       = r_bit;
            n_shift     = r_shift;
            n_capture   = r_capture;
            n_latch     = r_latch;
        end

        // Pin levels for this unit
        if (eff_phase == PH_IDLE) begin
            o_res.clock_out     = 1'b0;
            o_res.line_out      = 1'b1;
            o_res.line_drive    = 1'b1;
            o_res.reg_select_n  = 1'b1;
            o_res.fifo_select_n = 1'b1;
            o_res.busy_res      = 1'b0;
        end else begin
            o_res.clock_out     = (eff_phase == PH_BITS) && eff_bit[0];
            o_res.line_drive    = !released;
            o_res.line_out      = released ? 1'b0 :
                                  (eff_phase == PH_BITS) ? bitv : eff_latch;
            o_res.reg_select_n  = !is_reg;
            o_res.fifo_select_n = is_reg || (eff_phase == PH_GAP);
            o_res.busy_res      = 1'b1;
        end
        o_res.done_res   = last;
        o_res.read_valid = last && (eff_op == OP_REG_RD || eff_op == OP_FIFO_RD);
        o_res.read_byte  = o_res.read_valid ? eff_capture : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_active_op <= OP_TICK;
            r_unit      <= '0;
            r_bit       <= '0;
            r_shift     <= '0;
            r_capture   <= '1;
            r_latch     <= 1'b1;
        end else if (i_take) begin
            r_phase     <= n_phase;
            r_active_op <= n_active_op;
            r_unit      <= n_unit;
            r_bit       <= n_bit;
            r_shift     <= n_shift;
            r_capture   <= n_capture;
            r_latch     <= n_latch;
        end
    end

    a_idle_matches_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) == (r_active_op == OP_TICK))
        else $error("sequencer phase and active operation disagree");

    a_done_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && o_res.done_res) |=> (r_phase == PH_IDLE))
        else $error("transfer finished but sequencer not idle");

    a_busy_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && r_phase != PH_IDLE && i_operation != OP_TICK) |=>
        ($stable(r_phase) && $stable(r_bit) && $stable(r_unit)))
        else $error("command while busy advanced the transfer");

endmodule

// File: rtl/core/three_wire_spi_reg_fifo_master.sv
`timescale 1ns / 1ps
// Each result is registered into the result queue when its item is accepted.
// Throughput: one item per cycle while o_in_stall is low; the sequencer is clocked only on accepted items.
// A two-entry result queue decouples the sides, so input stall rises only when both are full.
// Reset (synchronous, active low): sequencer idle, line latch high, capture byte all ones,
// result queue empty. Depends on twspi_pkg and twspi_seq.
module three_wire_spi_reg_fifo_master (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [2:0]                      i_operation,
    input  logic [6:0]                      i_reg_address,
    input  logic [twspi_pkg::DATA_BITS-1:0] i_write_byte,
    input  logic                            i_line_in,
    // result channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_clock_out,
    output logic                            o_line_out,
    output logic                            o_line_drive,
    output logic                            o_reg_select_n,
    output logic                            o_fifo_select_n,
    output logic                            o_busy_res,
    output logic                            o_done_res,
    output logic [twspi_pkg::DATA_BITS-1:0] o_read_byte,
    output logic                            o_read_valid
);
    import twspi_pkg::*;

    t_result    seq_res;
    t_result    r_buf [2];
    t_result    head;
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count;
    logic       acc_in, acc_out;

    // Stall only when both queue slots hold results not yet taken
    assign o_in_stall  = (r_count == 2'd2);
    assign o_out_valid = (r_count != 2'd0);
    assign acc_in      = i_in_valid && !o_in_stall;
    assign acc_out     = o_out_valid && !i_out_stall;

    // Sequencer is clocked only on accepted items; a tick steps a busy transfer, a command starts one from idle
    twspi_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (acc_in),
        .i_operation   (i_operation),
        .i_reg_address (i_reg_address),
        .i_write_byte  (i_write_byte),
        .i_line_in     (i_line_in),
        .o_res         (seq_res)
    );

    // Result queue storage: write at the tail on accept
    always_ff @(posedge i_clk) begin
        if (acc_in) begin
            r_buf[r_wr_ptr] <= seq_res;
        end
    end

    // Queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (acc_in) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (acc_out) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({acc_in, acc_out})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Present the oldest result
    assign head            = r_buf[r_rd_ptr];
    assign o_clock_out     = head.clock_out;
    assign o_line_out      = head.line_out;
    assign o_line_drive    = head.line_drive;
    assign o_reg_select_n  = head.reg_select_n;
    assign o_fifo_select_n = head.fifo_select_n;
    assign o_busy_res      = head.busy_res;
    assign o_done_res      = head.done_res;
    assign o_read_byte     = head.read_byte;
    assign o_read_valid    = head.read_valid;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("result queue overfilled");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc_in && !acc_out) |=> (r_count == $past(r_count) + 2'd1))
        else $error("queue count missed an accepted item");

    a_ptr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd0 || r_count == 2'd2) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers disagree with fill count");

endmodule
